// ----- rtl/pncs_pkg.sv -----
// shared constants and controller/datapath interface types for the palette color search
`default_nettype none

package pncs_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int ADDR_W      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int IDX_W       = 8;
  localparam int COMP_W      = 8;
  localparam int SQ_W        = 2 * COMP_W;
  localparam int DIST_W      = 23;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;

  localparam logic [ADDR_W-1:0] ADDR_LAST   = ADDR_W'(PAL_ENTRIES - 1);
  localparam logic [IDX_W:0]    ENTRY_LIMIT = (IDX_W + 1)'(PAL_ENTRIES);

  localparam logic [6:0] WEIGHT_RED   = 7'd30;
  localparam logic [6:0] WEIGHT_GREEN = 7'd59;
  localparam logic [6:0] WEIGHT_BLUE  = 7'd11;

  // item kind carried on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic wr_en;     // store the incoming entry
    logic start;     // latch query color and begin the scan
    logic out_load;  // copy the best match into the output register
  } pncs_cmd_t;

  typedef struct packed {
    logic scan_done; // last entry has passed the compare stage
  } pncs_status_t;

endpackage

`default_nettype wire

// ----- rtl/palette_nearest_color_search_top.sv -----
// top level of the weighted nearest palette color search
`default_nettype none

// channel  direction  tdata                                          tuser
// in       slave      [7:0] entry_index [15:8] red [23:16] green     func
//                     [31:24] blue
// out      master     [7:0] nearest_index [30:8] min_distance        -
//
// a palette write leaves the controller idle, so the next item is accepted right after
// a query scans one entry per cycle from the single read port of the palette
// memory; no further item is accepted until its result is in the output register
// after reset all entries read as black through per-entry written flags, no clearing pass
// a result waiting on out_tready stalls the input only once the next query has
// finished its scan; writes and that query are still taken until then

module palette_nearest_color_search_top
  import pncs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // entry_index, red, green, blue
  input  wire logic                  in_tuser,  // func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata  // nearest_index, min_distance, zero pad
);

  pncs_cmd_t    cmd;
  pncs_status_t status;
  logic [IDX_W-1:0]  nearest_index;
  logic [DIST_W-1:0] min_distance;

  pncs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  pncs_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .entry_index   (in_tdata[7:0]),
    .red           (in_tdata[15:8]),
    .green         (in_tdata[23:16]),
    .blue          (in_tdata[31:24]),
    .nearest_index (nearest_index),
    .min_distance  (min_distance)
  );

  assign out_tdata = {{(OUT_DATA_W - IDX_W - DIST_W){1'b0}}, min_distance, nearest_index};

endmodule

`default_nettype wire

// ----- rtl/pncs_ctrl.sv -----
// controller state machine: input/output handshakes and scan sequencing
`default_nettype none

module pncs_ctrl
  import pncs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic         in_func,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output pncs_cmd_t         cmd,
  input  wire pncs_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // output register free or being emptied this cycle
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pncs_dpath.sv -----
// datapath: palette memory, pipelined distance unit, running minimum and output register
`default_nettype none

module pncs_dpath
  import pncs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pncs_cmd_t         cmd,
  output pncs_status_t           status,
  input  wire logic [IDX_W-1:0]  entry_index,
  input  wire logic [COMP_W-1:0] red,
  input  wire logic [COMP_W-1:0] green,
  input  wire logic [COMP_W-1:0] blue,
  output logic [IDX_W-1:0]       nearest_index,
  output logic [DIST_W-1:0]      min_distance
);

  logic [3*COMP_W-1:0] mem_r [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] vld_r;

  logic [COMP_W-1:0] q_red_r, q_green_r, q_blue_r;
  logic              iss_r;
  logic [ADDR_W-1:0] addr_r;
  logic              wr_ok;

  // stage 1: registered memory read
  logic              v1_r, first1_r, last1_r, rd_vld_r;
  logic [ADDR_W-1:0] idx1_r;
  logic [3*COMP_W-1:0] rd_data_r;
  logic [3*COMP_W-1:0] entry;
  logic [COMP_W-1:0]   dr, dg, db;

  // stage 2: squared differences
  logic              v2_r, first2_r, last2_r;
  logic [ADDR_W-1:0] idx2_r;
  logic [SQ_W-1:0]   sq_r_r, sq_g_r, sq_b_r;

  // stage 3: weighted distance
  logic              v3_r, first3_r, last3_r;
  logic [ADDR_W-1:0] idx3_r;
  logic [DIST_W-1:0] dist_r;

  logic [DIST_W-1:0] best_dist_r;
  logic [ADDR_W-1:0] best_idx_r;
  logic              done_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  assign wr_ok = cmd.wr_en && ({1'b0, entry_index} < ENTRY_LIMIT);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[entry_index[ADDR_W-1:0]] <= {red, green, blue};
    end
    rd_data_r <= mem_r[addr_r];
  end

  // per-entry written flags; an unwritten entry reads as black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[entry_index[ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_red_r   <= red;
      q_green_r <= green;
      q_blue_r  <= blue;
    end
  end

  // address sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= 1'b0;
      addr_r <= '0;
    end else if (cmd.start) begin
      iss_r  <= 1'b1;
      addr_r <= '0;
    end else if (iss_r) begin
      if (addr_r == ADDR_LAST) begin
        iss_r <= 1'b0;
      end else begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= iss_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r && last3_r;
    end
  end

  assign entry = rd_vld_r ? rd_data_r : '0;
  assign dr = (q_red_r > entry[3*COMP_W-1:2*COMP_W]) ?
              (q_red_r - entry[3*COMP_W-1:2*COMP_W]) :
              (entry[3*COMP_W-1:2*COMP_W] - q_red_r);
  assign dg = (q_green_r > entry[2*COMP_W-1:COMP_W]) ?
              (q_green_r - entry[2*COMP_W-1:COMP_W]) :
              (entry[2*COMP_W-1:COMP_W] - q_green_r);
  assign db = (q_blue_r > entry[COMP_W-1:0]) ?
              (q_blue_r - entry[COMP_W-1:0]) :
              (entry[COMP_W-1:0] - q_blue_r);

  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[addr_r];
    idx1_r   <= addr_r;
    first1_r <= (addr_r == '0);
    last1_r  <= (addr_r == ADDR_LAST);

    sq_r_r   <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_r   <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_r   <= SQ_W'(db) * SQ_W'(db);
    idx2_r   <= idx1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;

    dist_r   <= DIST_W'(sq_r_r) * DIST_W'(WEIGHT_RED)
              + DIST_W'(sq_g_r) * DIST_W'(WEIGHT_GREEN)
              + DIST_W'(sq_b_r) * DIST_W'(WEIGHT_BLUE);
    idx3_r   <= idx2_r;
    first3_r <= first2_r;
    last3_r  <= last2_r;
  end

  // running minimum, strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (v3_r && (first3_r || (dist_r < best_dist_r))) begin
      best_dist_r <= dist_r;
      best_idx_r  <= idx3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r  <= IDX_W'(best_idx_r);
      out_dist_r <= best_dist_r;
    end
  end

  assign status.scan_done = done_r;
  assign nearest_index    = out_idx_r;
  assign min_distance     = out_dist_r;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the palette nearest color search: directed table, then random traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pncs_pkg::*;

  localparam int unsigned W_RED   = 30;
  localparam int unsigned W_GREEN = 59;
  localparam int unsigned W_BLUE  = 11;
  localparam int RANDOM_ITEMS = 1600;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 700;

  typedef struct packed {
    logic              func;
    logic [7:0]        idx;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              chk;      // expected result typed into the row
    logic [7:0]        exp_idx;
    logic [DIST_W-1:0] exp_dist;
  } stim_row_t;

  typedef struct packed {
    logic [7:0]        idx;
    logic [DIST_W-1:0] distance;
  } match_t;

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{FUNC_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   23'd6502500},
    '{FUNC_QUERY, 8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 8'd0,   23'd1950750},
    '{FUNC_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 8'd0,   23'd3836475},
    '{FUNC_QUERY, 8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 8'd0,   23'd715275},
    '{FUNC_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 23'd0},
    '{FUNC_QUERY, 8'd0,   8'd128, 8'd128, 8'd128, 1'b1, 8'd255, 23'd1612900},
    '{FUNC_WRITE, 8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   23'd0},
    // white at both ends of the palette: lowest slot wins the tie
    '{FUNC_QUERY, 8'd0,   8'd200, 8'd200, 8'd200, 1'b1, 8'd0,   23'd302500},
    '{FUNC_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd1,   23'd0},
    '{FUNC_WRITE, 8'd128, 8'd1,   8'd2,   8'd3,   1'b0, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd1,   8'd2,   8'd3,   1'b1, 8'd128, 23'd0},
    '{FUNC_WRITE, 8'd200, 8'd170, 8'd85,  8'd85,  1'b0, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd85,  8'd170, 8'd170, 1'b0, 8'd0,   23'd0},
    '{FUNC_WRITE, 8'd1,   8'd0,   8'd0,   8'd1,   1'b0, 8'd0,   23'd0},
    '{FUNC_WRITE, 8'd2,   8'd0,   8'd0,   8'd1,   1'b0, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd0,   8'd0,   8'd1,   1'b1, 8'd1,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd3,   23'd0},
    '{FUNC_WRITE, 8'd85,  8'd85,  8'd170, 8'd85,  1'b0, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd90,  8'd160, 8'd80,  1'b0, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   23'd0},
    '{FUNC_WRITE, 8'd3,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   23'd0},
    '{FUNC_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd3,   23'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;  // entry_index, red, green, blue
  logic                  in_tuser;  // func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata; // nearest_index, min_distance, zero pad

  logic [23:0] palette_shadow [PAL_ENTRIES];
  match_t      match_q [$];
  stim_row_t   cur_item;
  bit          send_burst;
  int          err_count;
  int          idle_cycles;

  always #5 clk = ~clk;

  palette_nearest_color_search_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic match_t nearest_match(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    match_t      best;
    int unsigned dr, dg, db, d, best_d;
    logic [23:0] e;
    best   = '0;
    best_d = 0;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      e  = palette_shadow[i];
      dr = (r > e[23:16]) ? r - e[23:16] : e[23:16] - r;
      dg = (g > e[15:8])  ? g - e[15:8]  : e[15:8]  - g;
      db = (b > e[7:0])   ? b - e[7:0]   : e[7:0]   - b;
      d  = W_RED * dr * dr + W_GREEN * dg * dg + W_BLUE * db * db;
      // only a strictly smaller distance moves the best slot
      if (i == 0 || d < best_d) begin
        best_d   = d;
        best.idx = 8'(i);
      end
    end
    best.distance = DIST_W'(best_d);
    return best;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic stim_row_t random_item();
    stim_row_t   it;
    logic [23:0] c;
    int          sel;
    it      = '0;
    c       = palette_shadow[$urandom_range(0, PAL_ENTRIES - 1)];
    it.func = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_QUERY;
    // crowd the low slots now and then so duplicates and ties show up
    it.idx  = ($urandom_range(0, 9) < 2) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    sel     = $urandom_range(0, 99);
    if (sel < 40) begin
      {it.red, it.green, it.blue} = 24'($urandom);
    end else if (sel < 60) begin
      {it.red, it.green, it.blue} = c;
    end else if (sel < 80) begin
      it.red   = nudge(c[23:16]);
      it.green = nudge(c[15:8]);
      it.blue  = nudge(c[7:0]);
    end else begin
      it.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      it.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      it.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end
    return it;
  endfunction

  task automatic send_item(input stim_row_t it);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_item = it;
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {it.blue, it.green, it.red, it.idx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // transfer monitor, predictor and stall watchdog
  always @(posedge clk) begin : monitor
    match_t want;
    logic   accepted;
    accepted = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      accepted = 1'b1;
      if (in_tuser == FUNC_WRITE) begin
        // shadow keeps red in the top byte, blue in the bottom byte
        if (int'(in_tdata[7:0]) < PAL_ENTRIES)
          palette_shadow[in_tdata[7:0]] = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
      end else begin
        want = nearest_match(in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]);
        if (cur_item.chk) want = {cur_item.exp_idx, cur_item.exp_dist};
        match_q.push_back(want);
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      accepted = 1'b1;
      if (match_q.size() == 0) begin
        $display("%0t: result with nothing expected, index %0d distance %0d", $time,
                 out_tdata[7:0], out_tdata[8 +: DIST_W]);
        err_count++;
      end else begin
        want = match_q.pop_front();
        if (out_tdata[7:0] !== want.idx) begin
          $display("%0t: nearest_index expected %0d actual %0d", $time, want.idx,
                   out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[8 +: DIST_W] !== want.distance) begin
          $display("%0t: min_distance expected %0d actual %0d", $time, want.distance,
                   out_tdata[8 +: DIST_W]);
          err_count++;
        end
      end
    end
    idle_cycles = accepted ? 0 : idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("palette_nearest_color_search_top verification failed");
      $finish;
    end
  end

  // result side: random stalls, bursts, and two long hold-offs
  initial begin : sink
    int gap;
    int n_results;
    bit burst;
    out_tready = 1'b0;
    n_results  = 0;
    burst      = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (n_results % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 19);
      if (n_results == 20 || n_results == 400) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_results++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = FUNC_WRITE;
    cur_item    = '0;
    send_burst  = 1'b0;
    err_count   = 0;
    idle_cycles = 0;
    foreach (palette_shadow[k]) palette_shadow[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[k]) send_item(DIRECTED_ROWS[k]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_item(random_item());
    end
    in_tvalid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("palette_nearest_color_search_top verification clean");
    else
      $display("palette_nearest_color_search_top verification failed");
    $finish;
  end

endmodule
